// File: hw/rtl/sorted_keyed_point_table_assert.svh
// ----------------------------------------------------------------------------
// Sorted keyed point table assertion macros
// Shared property forms for the checkers of the sorted point table.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEYED_POINT_TABLE_ASSERT_SVH
`define SORTED_KEYED_POINT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SKPT_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("sorted point table check failed");

// Next-cycle implication, disabled during reset.
`define SKPT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("sorted point table check failed");

`endif

// File: hw/rtl/skpt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted keyed point table package
// Field widths, request and status codes, and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skpt_pkg;

	localparam int KEY_W      = 48;
	localparam int VAL_W      = 16;
	localparam int MODE_W     = 4;
	localparam int CURVE_W    = 32;
	localparam int CNT_W      = 7;
	localparam int REQ_W      = 3;
	localparam int STAT_W     = 2;
	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 112;

	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_FIND   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RANGE  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_NEW    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_HIT    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_MOVE,
		OP_FIND,
		OP_RANGE,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_ACT,
		S_EMIT
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [KEY_W-1:0]   key;
		logic [KEY_W-1:0]   key2;
		logic [VAL_W-1:0]   value;
		logic [MODE_W-1:0]  mode;
		logic [CURVE_W-1:0] curve;
	} req_t;

endpackage

// File: hw/rtl/skpt_front.sv
// ----------------------------------------------------------------------------
// Sorted keyed point table front end
// Accepts request transfers, decodes the request kind and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skpt_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [skpt_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [skpt_pkg::REQ_W-1:0]       s_tuser,
	output logic                             q_valid,
	input  logic                             q_ready,
	output skpt_pkg::req_t                   q_req
);

	skpt_pkg::req_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	skpt_pkg::req_t dec;
	logic           push;
	logic           pop;

	always_comb begin
		unique case (s_tuser)
			skpt_pkg::REQ_INSERT: dec.op = skpt_pkg::OP_INSERT;
			skpt_pkg::REQ_REMOVE: dec.op = skpt_pkg::OP_REMOVE;
			skpt_pkg::REQ_MOVE:   dec.op = skpt_pkg::OP_MOVE;
			skpt_pkg::REQ_FIND:   dec.op = skpt_pkg::OP_FIND;
			skpt_pkg::REQ_RANGE:  dec.op = skpt_pkg::OP_RANGE;
			default:              dec.op = skpt_pkg::OP_NOP;
		endcase
		dec.key   = s_tdata[47:0];
		dec.key2  = s_tdata[95:48];
		dec.value = s_tdata[111:96];
		dec.mode  = s_tdata[115:112];
		dec.curve = s_tdata[147:116];
	end

	assign s_tready = (fill_q != 2'd2);
	assign q_valid  = (fill_q != 2'd0);
	assign q_req    = fifo_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: hw/rtl/skpt_back.sv
// ----------------------------------------------------------------------------
// Sorted keyed point table back end
// Shifting cell array with a request sequencer and an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skpt_back #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  skpt_pkg::req_t                   q_req,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [skpt_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [skpt_pkg::STAT_W-1:0]      m_tuser,
	output logic                             m_tlast
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [KEY_BITS-1:0]          key_q   [CAPACITY];
	logic [skpt_pkg::VAL_W-1:0]   val_q   [CAPACITY];
	logic [skpt_pkg::MODE_W-1:0]  mode_q  [CAPACITY];
	logic [skpt_pkg::CURVE_W-1:0] curve_q [CAPACITY];

	skpt_pkg::state_t state_q, state_d;
	skpt_pkg::req_t   req_q;
	logic             phase2_q;
	logic [skpt_pkg::MODE_W-1:0]  mode_hold_q;
	logic [skpt_pkg::CURVE_W-1:0] curve_hold_q;
	logic [CAPACITY-1:0] lt_q, eq_q, le_q, mask_q;
	logic [CW-1:0]       count_q, count_d;

	logic [CAPACITY-1:0] vld, lt_c, eq_c, le_c, oh;
	logic [KEY_BITS-1:0] cmp_key, end_key;
	logic                hit, full, out_free;
	logic                do_cmp, do_ins, do_rem, do_rep, go_phase2, load_mask, step_mask;
	logic                emit, e_last;
	logic [skpt_pkg::STAT_W-1:0]  e_stat;
	logic [KEY_BITS-1:0]          w_key, sel_key;
	logic [skpt_pkg::VAL_W-1:0]   w_val, sel_val;
	logic [skpt_pkg::MODE_W-1:0]  w_mode, sel_mode, hit_mode;
	logic [skpt_pkg::CURVE_W-1:0] w_curve, sel_curve, hit_curve;
	logic                         e_entry;

	logic                         out_valid_q;
	logic [skpt_pkg::STAT_W-1:0]  out_stat_q;
	logic                         out_last_q;
	logic [skpt_pkg::KEY_W-1:0]   out_key_q;
	logic [skpt_pkg::VAL_W-1:0]   out_val_q;
	logic [skpt_pkg::MODE_W-1:0]  out_mode_q;
	logic [skpt_pkg::CURVE_W-1:0] out_curve_q;
	logic [skpt_pkg::CNT_W-1:0]   out_cnt_q;

	assign cmp_key  = phase2_q ? KEY_BITS'(req_q.key2) : KEY_BITS'(req_q.key);
	assign end_key  = KEY_BITS'(req_q.key2);
	assign hit      = |eq_q;
	assign full     = (count_q == CW'(CAPACITY));
	assign out_free = !out_valid_q || m_tready;
	assign oh       = mask_q & (~mask_q + 1'b1);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			vld[i]  = (CW'(i) < count_q);
			lt_c[i] = vld[i] && (key_q[i] < cmp_key);
			eq_c[i] = vld[i] && (key_q[i] == cmp_key);
			le_c[i] = vld[i] && (key_q[i] <= end_key);
		end
	end

	// One-hot selection of the reported cell and of the cell a move takes out.
	always_comb begin
		sel_key   = '0;
		sel_val   = '0;
		sel_mode  = '0;
		sel_curve = '0;
		hit_mode  = '0;
		hit_curve = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (oh[i]) begin
				sel_key   = sel_key | key_q[i];
				sel_val   = sel_val | val_q[i];
				sel_mode  = sel_mode | mode_q[i];
				sel_curve = sel_curve | curve_q[i];
			end
			if (eq_q[i]) begin
				hit_mode  = hit_mode | mode_q[i];
				hit_curve = hit_curve | curve_q[i];
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		q_ready   = 1'b0;
		do_cmp    = 1'b0;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		do_rep    = 1'b0;
		go_phase2 = 1'b0;
		load_mask = 1'b0;
		step_mask = 1'b0;
		emit      = 1'b0;
		e_last    = 1'b1;
		e_entry   = 1'b0;
		e_stat    = skpt_pkg::STAT_ABSENT;
		w_key     = KEY_BITS'(req_q.key);
		w_val     = req_q.value;
		w_mode    = req_q.mode;
		w_curve   = req_q.curve;
		unique case (state_q)
			skpt_pkg::S_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) state_d = skpt_pkg::S_CMP;
			end
			skpt_pkg::S_CMP: begin
				do_cmp  = 1'b1;
				state_d = skpt_pkg::S_ACT;
			end
			skpt_pkg::S_ACT: begin
				unique case (req_q.op)
					skpt_pkg::OP_INSERT, skpt_pkg::OP_MOVE: begin
						if (req_q.op == skpt_pkg::OP_MOVE && !phase2_q) begin
							if (hit) begin
								do_rem    = 1'b1;
								count_d   = count_q - 1'b1;
								go_phase2 = 1'b1;
								state_d   = skpt_pkg::S_CMP;
							end else if (out_free) begin
								emit    = 1'b1;
								state_d = skpt_pkg::S_IDLE;
							end
						end else if (out_free) begin
							emit    = 1'b1;
							state_d = skpt_pkg::S_IDLE;
							if (phase2_q) begin
								w_key   = end_key;
								w_mode  = mode_hold_q;
								w_curve = curve_hold_q;
							end
							if (hit) begin
								do_rep = 1'b1;
								e_stat = skpt_pkg::STAT_HIT;
							end else if (full) begin
								e_stat = skpt_pkg::STAT_FULL;
							end else begin
								do_ins  = 1'b1;
								count_d = count_q + 1'b1;
								e_stat  = skpt_pkg::STAT_NEW;
							end
						end
					end
					skpt_pkg::OP_REMOVE: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = skpt_pkg::S_IDLE;
							if (hit) begin
								do_rem  = 1'b1;
								count_d = count_q - 1'b1;
								e_stat  = skpt_pkg::STAT_HIT;
							end
						end
					end
					skpt_pkg::OP_FIND, skpt_pkg::OP_RANGE: begin
						load_mask = 1'b1;
						state_d   = skpt_pkg::S_EMIT;
					end
					default: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = skpt_pkg::S_IDLE;
						end
					end
				endcase
			end
			skpt_pkg::S_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (mask_q == '0) begin
						state_d = skpt_pkg::S_IDLE;
					end else begin
						e_entry   = 1'b1;
						e_stat    = skpt_pkg::STAT_HIT;
						step_mask = 1'b1;
						e_last    = ((mask_q & ~oh) == '0);
						if (e_last) state_d = skpt_pkg::S_IDLE;
					end
				end
			end
			default: state_d = skpt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skpt_pkg::S_IDLE;
			count_q     <= '0;
			phase2_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (q_valid && q_ready) phase2_q <= 1'b0;
			else if (go_phase2) phase2_q <= 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) req_q <= q_req;
		if (do_cmp) begin
			lt_q <= lt_c;
			eq_q <= eq_c;
			le_q <= le_c;
		end
		if (go_phase2) begin
			mode_hold_q  <= hit_mode;
			curve_hold_q <= hit_curve;
		end
		if (load_mask) begin
			mask_q <= (req_q.op == skpt_pkg::OP_FIND) ? eq_q : (le_q & ~lt_q);
		end else if (step_mask) begin
			mask_q <= mask_q & ~oh;
		end
		if (emit) begin
			out_stat_q  <= e_stat;
			out_last_q  <= e_last;
			out_key_q   <= e_entry ? skpt_pkg::KEY_W'(sel_key) : '0;
			out_val_q   <= e_entry ? sel_val : '0;
			out_mode_q  <= e_entry ? sel_mode : '0;
			out_curve_q <= e_entry ? sel_curve : '0;
			out_cnt_q   <= skpt_pkg::CNT_W'(count_d);
		end
	end

	// Each cell either holds, takes the new point, or shifts from a neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic at_pos;
		if (i == 0) begin : g_first
			assign at_pos = !lt_q[i];
		end else begin : g_rest
			assign at_pos = !lt_q[i] && lt_q[i-1];
		end
		always_ff @(posedge clk) begin
			if ((do_rep && eq_q[i]) || (do_ins && at_pos)) begin
				key_q[i]   <= w_key;
				val_q[i]   <= w_val;
				mode_q[i]  <= w_mode;
				curve_q[i] <= w_curve;
			end else if (do_ins && !lt_q[i]) begin
				if (i > 0) begin
					key_q[i]   <= key_q[(i > 0) ? i - 1 : 0];
					val_q[i]   <= val_q[(i > 0) ? i - 1 : 0];
					mode_q[i]  <= mode_q[(i > 0) ? i - 1 : 0];
					curve_q[i] <= curve_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_rem && !lt_q[i]) begin
				if (i < CAPACITY - 1) begin
					key_q[i]   <= key_q[(i < CAPACITY - 1) ? i + 1 : i];
					val_q[i]   <= val_q[(i < CAPACITY - 1) ? i + 1 : i];
					mode_q[i]  <= mode_q[(i < CAPACITY - 1) ? i + 1 : i];
					curve_q[i] <= curve_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_cnt_q, out_curve_q, out_mode_q, out_val_q, out_key_q};

endmodule

// File: hw/rtl/sorted_keyed_point_table.sv
// ----------------------------------------------------------------------------
// Sorted keyed point table
// Ordered table of keyed points with insert, remove, move, find and range.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                tuser     tlast
//  s_*      in   key, key_end, value, interp, curve   req_type  -
//  m_*      out  key, value, interp, curve, count     status    last result
//
//  Insert and remove pass through the compare and act states to the result, a
//  find also loads its match mask first and reports from the emit state, and a
//  move takes its entry out and puts it back through the cell array.
//  A range query holds the sequencer until it has emitted its last result.
//  The rate is set by the single sequencer over the shifting cell array; a
//  two-entry request queue and the output register let either side stall.
//  Reset clears the fill count and control state, not the cells; no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_keyed_point_table #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// key, key_end, point_value, interp_mode, curve_shape, zero fill
	input  logic [skpt_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type
	input  logic [skpt_pkg::REQ_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_key, out_value, out_interp, out_curve, entry_count, zero fill
	output logic [skpt_pkg::OUT_DATA_W-1:0]  m_tdata,
	// status
	output logic [skpt_pkg::STAT_W-1:0]      m_tuser,
	output logic                             m_tlast
);

	logic           q_valid;
	logic           q_ready;
	skpt_pkg::req_t q_req;

	skpt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_req    (q_req)
	);

	skpt_back #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_req    (q_req),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: hw/rtl/skpt_checker.sv
// ----------------------------------------------------------------------------
// Sorted keyed point table checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_keyed_point_table_assert.svh"

module skpt_checker #(
	parameter int CAPACITY = 64
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [skpt_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [skpt_pkg::STAT_W-1:0]     m_tuser,
	input logic                            m_tlast
);

	logic [skpt_pkg::CNT_W-1:0] cnt;
	logic                       is_full;

	assign cnt     = m_tdata[106:100];
	assign is_full = (m_tuser == skpt_pkg::STAT_FULL);

	`SKPT_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`SKPT_ASSERT_IMPLY(a_count, clk, arst_n, m_tvalid, cnt <= skpt_pkg::CNT_W'(CAPACITY))
	`SKPT_ASSERT_IMPLY(a_full, clk, arst_n, m_tvalid && is_full, cnt == skpt_pkg::CNT_W'(CAPACITY) && m_tlast)
	`SKPT_ASSERT_IMPLY(a_absent, clk, arst_n, m_tvalid && m_tuser == skpt_pkg::STAT_ABSENT, m_tlast && m_tdata[99:0] == '0)

endmodule

bind sorted_keyed_point_table skpt_checker #(.CAPACITY(CAPACITY)) u_skpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
